// ===== rtl/core/next_fit_block_allocator_unit_defines.svh =====
// Assertion macros for the next-fit block allocator.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset.
`define NFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define NFBA_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define NFBA_ASSERT(label, prop, msg)
`define NFBA_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== rtl/core/nfba_pkg.sv =====
// Shared types and constants of the next-fit block allocator.
package nfba_pkg;

  // Bytes taken by one block header in front of each payload.
  localparam int unsigned HdrBytes = 5;

  // Request kinds.
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNoFit   = 2'd1,
    StatusBadAddr = 2'd2
  } status_e;

  // One request item.
  typedef struct packed {
    logic        req_type;
    logic [11:0] alloc_size;
    logic [11:0] block_address;
  } req_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [11:0] payload_offset;
    logic [11:0] free_bytes;
  } rsp_t;

endpackage

// ===== rtl/core/next_fit_block_allocator_unit.sv =====
// Top level of the next-fit block allocator: header memory, search sequencer, result register.
//
//   Channel   Signals                        Direction  Carries
//   request   in_valid_i/in_ready_o/in_req_i   in       one allocate or free item
//   result    out_valid_o/out_ready_i/out_rsp_o out     status, offset, free bytes
//
// After reset a clearing pass writes every header entry, one per cycle; no item is
// accepted during that pass. An allocate reads one header per block visited by the walk,
// then splits the block if needed and registers the result; an oversized allocate goes
// straight to the result, a free takes a header read, an update and the result.
// A result waits in the output register while the next item is accepted; the block
// stalls only when a new result is ready and the previous one has not been taken.
`include "next_fit_block_allocator_unit_defines.svh"

module next_fit_block_allocator_unit #(
  parameter int unsigned ARENA_BYTES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nfba_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nfba_pkg::rsp_t out_rsp_o
);
  import nfba_pkg::*;

  // Address width and a compute width that holds sums of two offsets and a header.
  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned CW = ((AW > 12) ? AW : 12) + 2;
  localparam logic [CW-1:0] ArenaC = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HdrC   = CW'(HdrBytes);
  localparam logic [AW-1:0] HdrA   = AW'(HdrBytes);
  localparam logic [AW-1:0] LastA  = AW'(ARENA_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StWalk  = 3'd2;
  localparam logic [2:0] StSplit = 3'd3;
  localparam logic [2:0] StFree  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  // One header entry per payload offset.
  typedef struct packed {
    logic          start;
    logic          used;
    logic [AW-1:0] size;
  } hdr_t;

  localparam hdr_t InitHdr = '{start: 1'b1, used: 1'b0, size: AW'(ARENA_BYTES - HdrBytes)};

  hdr_t          hdr_mem_q [ARENA_BYTES];
  hdr_t          rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  hdr_t          wr_data;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] rover_q, rover_d;
  logic [AW-1:0] free_total_q, free_total_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW:0]   guard_q, guard_d;
  logic          out_valid_q, out_valid_d;
  logic          load_out;

  logic [AW-1:0] want_q;
  logic [CW-1:0] rest_q, rest_d;
  logic [AW-1:0] rsize_q, rsize_d;
  status_e       res_status_q, res_status_d;
  logic [11:0]   res_off_q, res_off_d;
  rsp_t          out_rsp_q;

  logic          in_fire;
  logic [AW:0]   guard_inc;
  logic [CW-1:0] next_sum;
  logic [AW-1:0] next_blk;
  logic [CW-1:0] want_hdr;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // Header memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= hdr_mem_q[rd_addr];
  end

  // Walk arithmetic on the header that was just read.
  assign guard_inc = guard_q + 1'b1;
  assign next_sum  = CW'(cur_q) + CW'(rd_data_q.size) + HdrC;
  assign next_blk  = (next_sum >= ArenaC) ? HdrA : AW'(next_sum);
  assign want_hdr  = CW'(want_q) + HdrC;

  // Sequencer next state. Writes to the memory happen only in steps that issue no
  // read for a later step, so no read whose data is used meets a write to the same entry.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rover_d      = rover_q;
    free_total_d = free_total_q;
    cur_d        = cur_q;
    guard_d      = guard_q;
    out_valid_d  = out_valid_q;
    load_out     = 1'b0;
    rest_d       = rest_q;
    rsize_d      = rsize_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    rd_addr      = cur_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q;
    wr_data      = rd_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = (clr_q == HdrA) ? InitHdr : '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LastA) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          res_off_d = '0;
          if (in_req_i.req_type == ReqAlloc) begin
            if (CW'(in_req_i.alloc_size) >= ArenaC) begin
              res_status_d = StatusNoFit;
              state_d      = StDone;
            end else begin
              rd_addr = rover_q;
              cur_d   = rover_q;
              guard_d = '0;
              state_d = StWalk;
            end
          end else begin
            if (CW'(in_req_i.block_address) >= ArenaC) begin
              res_status_d = StatusBadAddr;
              state_d      = StDone;
            end else begin
              rd_addr = AW'(in_req_i.block_address);
              cur_d   = AW'(in_req_i.block_address);
              state_d = StFree;
            end
          end
        end
      end
      StWalk: begin
        rest_d  = CW'(cur_q) + want_hdr;
        rsize_d = rd_data_q.size - want_q - HdrA;
        if (!rd_data_q.used && (rd_data_q.size == want_q)) begin
          // Exact fit: mark used, rover stays.
          wr_en        = 1'b1;
          wr_data.used = 1'b1;
          free_total_d = free_total_q - want_q;
          res_status_d = StatusOk;
          res_off_d    = 12'(cur_q);
          state_d      = StDone;
        end else if (!rd_data_q.used && (CW'(rd_data_q.size) > want_hdr)) begin
          // Split: shrink this block, the remainder header follows.
          wr_en        = 1'b1;
          wr_data.used = 1'b1;
          wr_data.size = want_q;
          free_total_d = free_total_q - want_q - HdrA;
          res_status_d = StatusOk;
          res_off_d    = 12'(cur_q);
          state_d      = StSplit;
        end else if ((next_blk != rover_q) && (CW'(guard_inc) < ArenaC)) begin
          rd_addr = next_blk;
          cur_d   = next_blk;
          guard_d = guard_inc;
        end else begin
          res_status_d = StatusNoFit;
          res_off_d    = '0;
          state_d      = StDone;
        end
      end
      StSplit: begin
        if (rest_q < ArenaC) begin
          wr_en   = 1'b1;
          wr_addr = AW'(rest_q);
          wr_data = '{start: 1'b1, used: 1'b0, size: rsize_q};
          rover_d = AW'(rest_q);
        end
        state_d = StDone;
      end
      StFree: begin
        if (rd_data_q.start) begin
          if (rd_data_q.used) begin
            wr_en        = 1'b1;
            wr_data.used = 1'b0;
            free_total_d = free_total_q + rd_data_q.size;
          end
          res_status_d = StatusOk;
        end else begin
          res_status_d = StatusBadAddr;
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      rover_q      <= HdrA;
      free_total_q <= AW'(ARENA_BYTES - HdrBytes);
      cur_q        <= '0;
      guard_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      rover_q      <= rover_d;
      free_total_q <= free_total_d;
      cur_q        <= cur_d;
      guard_q      <= guard_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      want_q <= AW'(in_req_i.alloc_size);
    end
    rest_q       <= rest_d;
    rsize_q      <= rsize_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    if (load_out) begin
      out_rsp_q.status         <= res_status_q;
      out_rsp_q.payload_offset <= res_off_q;
      out_rsp_q.free_bytes     <= 12'(free_total_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Checks on the sequencer and the bookkeeping.
  `NFBA_ASSERT(a_free_total_bound, free_total_q <= InitHdr.size, "free byte count too high")
  `NFBA_ASSERT(a_rover_range, rover_q >= HdrA, "rover points into the first header")
  `NFBA_ASSERT(a_accept_leaves_idle, in_fire |=> (state_q != StIdle), "accepted item did not start")
  `NFBA_ASSERT_NEVER(a_no_write_in_idle, wr_en && (state_q == StIdle), "header write while idle")

endmodule

// ===== tb/next_fit_block_allocator_unit_tb.sv =====
// Self-checking testbench for the next-fit block allocator with a built-in arena predictor.
module next_fit_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfba_pkg::*;

  localparam int unsigned ArenaBytes = 4096;
  localparam int unsigned PhaseItems = 270;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned RunLimit = 4_000_000;

  // Traffic shaping of each random phase.
  typedef enum int unsigned {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_phase_e;

  // One row of the directed table; typed rows carry a result known by inspection.
  typedef struct packed {
    logic        kind;
    logic [11:0] size;
    logic [11:0] addr;
    logic        typed;
    status_e     st;
    logic [11:0] off;
    logic [11:0] fb;
  } dir_row_t;

  localparam dir_row_t DirRows [20] = '{
    // Free of the single free block after reset: a double free.
    '{ReqFree,  12'd4095, 12'd5,    1'b1, StatusOk,      12'd0,    12'd4091},
    // Addresses at both ends of the arena that are no block start.
    '{ReqFree,  12'd0,    12'd0,    1'b1, StatusBadAddr, 12'd0,    12'd4091},
    '{ReqFree,  12'd0,    12'd4095, 1'b1, StatusBadAddr, 12'd0,    12'd4091},
    // Largest request never fits.
    '{ReqAlloc, 12'd4095, 12'd4095, 1'b1, StatusNoFit,   12'd0,    12'd4091},
    // Exact fit of the whole arena, then nothing left for a zero-size request.
    '{ReqAlloc, 12'd4091, 12'd0,    1'b1, StatusOk,      12'd5,    12'd0},
    '{ReqAlloc, 12'd0,    12'd0,    1'b1, StatusNoFit,   12'd0,    12'd0},
    '{ReqFree,  12'd0,    12'd5,    1'b1, StatusOk,      12'd0,    12'd4091},
    // Zero-size split, then an exact fit of the remainder.
    '{ReqAlloc, 12'd0,    12'd4095, 1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqAlloc, 12'd4086, 12'd0,    1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqFree,  12'd4095, 12'd10,   1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqFree,  12'd0,    12'd5,    1'b0, StatusOk,      12'd0,    12'd0},
    // A block exactly header bytes larger than the request is not split.
    '{ReqAlloc, 12'd4081, 12'd0,    1'b1, StatusNoFit,   12'd0,    12'd4086},
    // Split that leaves a one-byte block at the last offset.
    '{ReqAlloc, 12'd4080, 12'd0,    1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqAlloc, 12'd1,    12'd0,    1'b1, StatusOk,      12'd4095, 12'd0},
    '{ReqFree,  12'd0,    12'd4095, 1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqFree,  12'd0,    12'd4094, 1'b1, StatusBadAddr, 12'd0,    12'd1},
    // Walk wraps from the last block to the first and fits there.
    '{ReqAlloc, 12'd0,    12'd0,    1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqFree,  12'd0,    12'd10,   1'b0, StatusOk,      12'd0,    12'd0},
    '{ReqFree,  12'd0,    12'd5,    1'b0, StatusOk,      12'd0,    12'd0},
    // Address inside a block.
    '{ReqFree,  12'd0,    12'd7,    1'b1, StatusBadAddr, 12'd0,    12'd4081}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  // Predicted arena: one header slot per payload offset.
  bit          blk_start [ArenaBytes];
  bit          blk_used [ArenaBytes];
  int unsigned blk_size [ArenaBytes];
  int unsigned rover_pos;
  int unsigned free_sum;

  rsp_t        due_results [$];
  int unsigned held_blocks [$];
  int unsigned released_blocks [$];

  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned hold_left = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  next_fit_block_allocator_unit #(
    .ARENA_BYTES(ArenaBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the predicted arena and returns its result.
  function automatic rsp_t serve_request(req_t item);
    rsp_t        res;
    int unsigned want;
    int unsigned addr;
    int unsigned cur;
    int unsigned rest;
    int unsigned steps;
    bit          done;
    res.status         = StatusNoFit;
    res.payload_offset = '0;
    want = 32'(item.alloc_size);
    addr = 32'(item.block_address);
    if (item.req_type == ReqAlloc) begin
      if (want < ArenaBytes && rover_pos < ArenaBytes) begin
        cur   = rover_pos;
        steps = 0;
        done  = 1'b0;
        // Walk from the rover, at most once around the arena.
        while (!done) begin
          if (!blk_used[cur] && blk_size[cur] == want) begin
            blk_used[cur] = 1'b1;
            free_sum -= want;
            res.status         = StatusOk;
            res.payload_offset = 12'(cur);
            done = 1'b1;
          end else if (!blk_used[cur] && blk_size[cur] > want + HdrBytes) begin
            // Split: the remainder becomes a new free block and the rover moves to it.
            rest = cur + want + HdrBytes;
            if (rest < ArenaBytes) begin
              blk_start[rest] = 1'b1;
              blk_used[rest]  = 1'b0;
              blk_size[rest]  = blk_size[cur] - want - HdrBytes;
              rover_pos       = rest;
            end
            blk_used[cur] = 1'b1;
            blk_size[cur] = want;
            free_sum -= want + HdrBytes;
            res.status         = StatusOk;
            res.payload_offset = 12'(cur);
            done = 1'b1;
          end else begin
            cur = cur + blk_size[cur] + HdrBytes;
            if (cur >= ArenaBytes) begin
              cur = HdrBytes;
            end
            steps++;
            if (cur == rover_pos || steps >= ArenaBytes) begin
              done = 1'b1;
            end
          end
        end
      end
    end else if (addr < ArenaBytes && blk_start[addr]) begin
      if (blk_used[addr]) begin
        blk_used[addr] = 1'b0;
        free_sum += blk_size[addr];
      end
      res.status = StatusOk;
    end else begin
      res.status = StatusBadAddr;
    end
    res.free_bytes = 12'(free_sum);
    return res;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offers one item from a falling edge on and books its expected result on acceptance.
  task automatic send_item(req_t item, bit typed, rsp_t typed_rsp);
    rsp_t calc;
    int   idx;
    idx = -1;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = item;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    calc = serve_request(item);
    due_results.push_back(typed ? typed_rsp : calc);
    // Track live and released blocks to steer the random requests.
    if (calc.status == StatusOk) begin
      if (item.req_type == ReqAlloc) begin
        held_blocks.push_back(32'(calc.payload_offset));
      end else begin
        foreach (held_blocks[i]) begin
          if (held_blocks[i] == 32'(item.block_address)) begin
            idx = i;
          end
        end
        if (idx >= 0) begin
          held_blocks.delete(idx);
        end
        released_blocks.push_back(32'(item.block_address));
        if (released_blocks.size() > 32) begin
          void'(released_blocks.pop_front());
        end
      end
    end
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every booked result has come back.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("result with no request pending: status %0d offset %0d free %0d",
                             out_rsp_o.status, out_rsp_o.payload_offset,
                             out_rsp_o.free_bytes));
      end else begin
        want = due_results.pop_front();
        if (out_rsp_o.status !== want.status) begin
          flag_error($sformatf("status got %0d expected %0d",
                               out_rsp_o.status, want.status));
        end
        if (out_rsp_o.payload_offset !== want.payload_offset) begin
          flag_error($sformatf("payload_offset got %0d expected %0d",
                               out_rsp_o.payload_offset, want.payload_offset));
        end
        if (out_rsp_o.free_bytes !== want.free_bytes) begin
          flag_error($sformatf("free_bytes got %0d expected %0d",
                               out_rsp_o.free_bytes, want.free_bytes));
        end
      end
    end
  end

  // Watchdog on the whole run, clearing pass included.
  initial begin
    while (cycle_count < RunLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("next_fit_block_allocator_unit_tb failed");
    $finish;
  end

  // Main sequence: reset, directed table, then four random phases.
  initial begin
    req_t        item;
    rsp_t        typed_rsp;
    idle_phase_e phase;
    int unsigned roll;
    int unsigned pick;
    int unsigned size;

    // After reset the arena is one free block at offset 5.
    foreach (blk_start[i]) begin
      blk_start[i] = 1'b0;
      blk_used[i]  = 1'b0;
      blk_size[i]  = 0;
    end
    blk_start[HdrBytes] = 1'b1;
    blk_size[HdrBytes]  = ArenaBytes - HdrBytes;
    rover_pos = HdrBytes;
    free_sum  = ArenaBytes - HdrBytes;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirRows[i]) begin
      item.req_type          = DirRows[i].kind;
      item.alloc_size        = DirRows[i].size;
      item.block_address     = DirRows[i].addr;
      typed_rsp.status         = DirRows[i].st;
      typed_rsp.payload_offset = DirRows[i].off;
      typed_rsp.free_bytes     = DirRows[i].fb;
      send_item(item, DirRows[i].typed, typed_rsp);
    end
    drain_results();

    phase = IdleNone;
    repeat (4) begin
      unique case (phase)
        IdleNone: begin
          send_pct  = 0;
          recv_pct  = 0;
          hold_left = HoldCycles;
        end
        IdleSender: begin
          send_pct = 83;
          recv_pct = 0;
        end
        IdleReceiver: begin
          send_pct = 0;
          recv_pct = 83;
        end
        default: begin
          send_pct = 33;
          recv_pct = 33;
        end
      endcase
      @(negedge clk_i);
      repeat (PhaseItems) begin
        roll = $urandom_range(99);
        item.alloc_size    = 12'($urandom_range(4095));
        item.block_address = 12'($urandom_range(4095));
        // Lean toward frees when the arena runs low.
        if (held_blocks.size() == 0 || (free_sum >= 500 && roll < 45) ||
            (free_sum < 500 && roll < 15)) begin
          item.req_type = ReqAlloc;
          pick = $urandom_range(99);
          size = 32'(item.alloc_size);
          if (pick < 5) begin
            size = $urandom_range(4);
          end else if (pick < 25 && released_blocks.size() != 0) begin
            // Size of a recently freed block, to hit exact fits.
            size = blk_size[released_blocks[$urandom_range(released_blocks.size() - 1)]];
          end else if (pick < 85) begin
            size = $urandom_range(200, 8);
          end else if (pick < 95) begin
            size = $urandom_range(1200, 200);
          end
          item.alloc_size = 12'(size);
        end else begin
          item.req_type = ReqFree;
          if (roll < 85) begin
            item.block_address = 12'(held_blocks[$urandom_range(held_blocks.size() - 1)]);
          end else if (roll < 92 && released_blocks.size() != 0) begin
            item.block_address =
              12'(released_blocks[$urandom_range(released_blocks.size() - 1)]);
          end
        end
        send_item(item, 1'b0, typed_rsp);
      end
      drain_results();
      phase = phase.next();
    end

    if (error_count == 0) begin
      $display("next_fit_block_allocator_unit_tb passed");
    end else begin
      $display("next_fit_block_allocator_unit_tb failed");
    end
    $finish;
  end

endmodule
